>>> rtl/oam_event_log_table_macros.svh
// Assertion macros for the event log table checker.
// Expects clk and arst_n in the scope of each use.
`ifndef OAM_EVENT_LOG_TABLE_MACROS_SVH
`define OAM_EVENT_LOG_TABLE_MACROS_SVH

// same-cycle implication
`define OELT_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("event log table check failed");

// next-cycle implication
`define OELT_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("event log table check failed");

`endif

>>> rtl/oelt_pkg.sv
// Types and constants for the event log table.
// No dependencies; used by oelt_ram, oelt_ctrl, the top level and the checker.
package oelt_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int CAP_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
	localparam logic [7:0] TYPE_LIMIT = 8'd4;
	localparam logic [63:0] ALL_ONES64 = 64'hffff_ffff_ffff_ffff;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_GET     = 2'd1,
		OP_GETNEXT = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_NO_NEXT   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_CLEAR,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] iface;
		logic [31:0] idx;
		logic [7:0]  etype;
		logic        remote;
		logic [63:0] value;
		logic [63:0] thresh;
		logic [63:0] window;
		logic [31:0] stamp;
	} rec_t;

	// data.idx carries the key log index of get and getnext
	typedef struct packed {
		op_t  op;
		rec_t data;
	} req_t;

	typedef struct packed {
		status_t status;
		rec_t    rec;
	} rsp_t;

endpackage

>>> rtl/oelt_ifs.sv
// Channel interfaces of the event log table: request, response, config write.
// No dependencies.
interface oelt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] interface_id;
	logic [31:0] key_log_index;
	logic [7:0]  event_type;
	logic        is_remote;
	logic [63:0] event_value;
	logic [63:0] threshold;
	logic [63:0] window;
	logic [31:0] timestamp;

	modport source (output valid, opcode, interface_id, key_log_index, event_type,
		is_remote, event_value, threshold, window, timestamp, input ready);
	modport sink (input valid, opcode, interface_id, key_log_index, event_type,
		is_remote, event_value, threshold, window, timestamp, output ready);
endinterface

interface oelt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] out_interface_id;
	logic [31:0] out_log_index;
	logic [7:0]  out_event_type;
	logic        out_is_remote;
	logic [63:0] out_value;
	logic [63:0] out_threshold;
	logic [63:0] out_window;
	logic [31:0] out_timestamp;

	modport source (output valid, status, out_interface_id, out_log_index,
		out_event_type, out_is_remote, out_value, out_threshold, out_window,
		out_timestamp, input ready);
	modport sink (input valid, status, out_interface_id, out_log_index,
		out_event_type, out_is_remote, out_value, out_threshold, out_window,
		out_timestamp, output ready);
endinterface

interface oelt_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] log_capacity;

	modport source (output valid, log_capacity, input ready);
	modport sink (input valid, log_capacity, output ready);
endinterface

>>> rtl/oelt_ram.sv
// Record memory of the event log table, one write and one registered read port.
// Depends on oelt_pkg.
module oelt_ram #(
	parameter int DEPTH = oelt_pkg::MAX_ENTRIES_DEF,
	parameter int AW = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  oelt_pkg::rec_t   wdata,
	input  logic [AW-1:0]    raddr,
	output oelt_pkg::rec_t   rdata
);
	import oelt_pkg::*;

	rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/oelt_ctrl.sv
// Sequencer of the event log table: ring pointers, add/clear, slot scan, result register.
// Depends on oelt_pkg; drives oelt_ram.
module oelt_ctrl #(
	parameter int MAX_ENTRIES = oelt_pkg::MAX_ENTRIES_DEF,
	parameter int AW = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [oelt_pkg::CAP_W-1:0] cap,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  oelt_pkg::req_t             in_req,
	output logic                       out_valid,
	input  logic                       out_ready,
	output oelt_pkg::rsp_t             out_rsp,
	output logic                       mem_we,
	output logic [AW-1:0]              mem_waddr,
	output oelt_pkg::rec_t             mem_wdata,
	output logic [AW-1:0]              mem_raddr,
	input  oelt_pkg::rec_t             mem_rdata
);
	import oelt_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = CW + 1;
	localparam logic [IW-1:0] MAX_W = IW'(MAX_ENTRIES);
	localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_ENTRIES - 1);

	state_t state_q, state_d;
	req_t req_q;
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] used_q;
	logic [31:0] next_idx_q;
	logic [AW-1:0] scan_q;
	logic rd_v_s1;
	logic [AW-1:0] slot_s1;
	logic found_q;
	rec_t best_q;
	logic out_valid_q;
	rsp_t out_rsp_q;

	logic out_free, out_load;
	logic [31:0] cap32;
	logic [IW-1:0] cap_eff, used_w, oldest_w, slot_sum, old_sum, used_new;
	logic [IW-1:0] slot_w, off_w;
	logic ent_ok, ent_hit, ent_above, ent_better;
	logic [AW-1:0] add_slot;
	rec_t add_rec;
	rsp_t rsp_d;
	logic mask;

	assign out_free = !out_valid_q || out_ready;

	// ring bookkeeping for add
	always_comb begin
		cap32 = 32'(cap);
		if (cap32 == 32'd0) begin
			cap_eff = IW'(1);
		end else if (cap32 > 32'(MAX_ENTRIES)) begin
			cap_eff = MAX_W;
		end else begin
			cap_eff = IW'(cap32);
		end
		used_w = IW'(used_q);
		oldest_w = IW'(oldest_q);
		slot_sum = oldest_w + used_w;
		if (slot_sum >= MAX_W) begin
			slot_sum = slot_sum - MAX_W;
		end
		add_slot = AW'(slot_sum);
		if (used_w >= cap_eff) begin
			old_sum = oldest_w + (used_w - cap_eff + IW'(1));
			if (old_sum >= MAX_W) begin
				old_sum = old_sum - MAX_W;
			end
			used_new = cap_eff;
		end else begin
			old_sum = oldest_w;
			used_new = used_w + IW'(1);
		end
		add_rec = req_q.data;
		add_rec.idx = next_idx_q + 32'd1;
	end

	// scan compare on the read data
	always_comb begin
		slot_w = IW'(slot_s1);
		if (slot_w >= oldest_w) begin
			off_w = slot_w - oldest_w;
		end else begin
			off_w = slot_w + MAX_W - oldest_w;
		end
		ent_ok = rd_v_s1 && (off_w < used_w);
		ent_hit = (mem_rdata.iface == req_q.data.iface) && (mem_rdata.idx == req_q.data.idx);
		ent_above = {mem_rdata.iface, mem_rdata.idx} > {req_q.data.iface, req_q.data.idx};
		ent_better = !found_q || ({best_q.iface, best_q.idx} > {mem_rdata.iface, mem_rdata.idx});
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		mem_we = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_req.op)
						OP_ADD: state_d = S_ADD;
						OP_CLEAR: state_d = S_CLEAR;
						OP_GET, OP_GETNEXT: state_d = S_SCAN;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_q == LAST_SLOT) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_DONE;
			S_ADD: begin
				if (out_free) begin
					mem_we = 1'b1;
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_CLEAR, S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result word
	always_comb begin
		mask = best_q.remote || (best_q.etype > TYPE_LIMIT);
		rsp_d = '0;
		rsp_d.status = ST_OK;
		if (state_q == S_ADD) begin
			rsp_d.rec = add_rec;
		end else if (state_q == S_DONE) begin
			if (!found_q) begin
				rsp_d.status = (req_q.op == OP_GET) ? ST_NOT_FOUND : ST_NO_NEXT;
			end else begin
				rsp_d.rec = best_q;
				if (req_q.op == OP_GET && mask) begin
					rsp_d.rec.value = ALL_ONES64;
					rsp_d.rec.thresh = ALL_ONES64;
					rsp_d.rec.window = ALL_ONES64;
				end
			end
		end
	end

	assign mem_waddr = add_slot;
	assign mem_wdata = add_rec;
	assign mem_raddr = scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			oldest_q <= '0;
			used_q <= '0;
			next_idx_q <= '0;
			scan_q <= '0;
			rd_v_s1 <= 1'b0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == S_SCAN);
			if (state_q == S_IDLE && in_valid) begin
				scan_q <= '0;
				found_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				scan_q <= scan_q + AW'(1);
			end
			if (ent_ok) begin
				if (req_q.op == OP_GET) begin
					if (ent_hit) begin
						found_q <= 1'b1;
					end
				end else if (ent_above && ent_better) begin
					found_q <= 1'b1;
				end
			end
			if (out_load && state_q == S_ADD) begin
				oldest_q <= AW'(old_sum);
				used_q <= CW'(used_new);
				next_idx_q <= next_idx_q + 32'd1;
			end else if (out_load && state_q == S_CLEAR) begin
				oldest_q <= '0;
				used_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_req;
		end
		slot_s1 <= scan_q;
		if (ent_ok) begin
			if (req_q.op == OP_GET) begin
				if (ent_hit) begin
					best_q <= mem_rdata;
				end
			end else if (ent_above && ent_better) begin
				best_q <= mem_rdata;
			end
		end
		if (out_load) begin
			out_rsp_q <= rsp_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp = out_rsp_q;

endmodule

>>> rtl/oam_event_log_table.sv
// Top level of the event log table: config register, sequencer and record memory.
// Depends on oelt_pkg, oelt_ifs, oelt_ram, oelt_ctrl.
//
//   channel  role   handshake    payload
//   req      sink   valid/ready  opcode, key and record fields
//   rsp      source valid/ready  status and record fields
//   cfg      sink   valid/ready  log_capacity
//
// Add and clear go from accept through their own state to the output register.
// Get and getnext scan every slot, one memory read per slot.
// A new item is taken while the previous result waits in the output register.
// A result held by rsp.ready stalls the next add or clear and the end of a scan.
// Reset empties the log, sets the log index to 0 and the capacity to 64.
module oam_event_log_table #(
	parameter int MAX_ENTRIES = oelt_pkg::MAX_ENTRIES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	oelt_req_if.sink   req,
	oelt_rsp_if.source rsp,
	oelt_cfg_if.sink   cfg
);
	import oelt_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [CAP_W-1:0] cap_q;
	req_t in_req;
	rsp_t out_rsp;
	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	rec_t mem_wdata, mem_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.log_capacity;
		end
	end

	always_comb begin
		in_req.op = op_t'(req.opcode);
		in_req.data.iface = req.interface_id;
		in_req.data.idx = req.key_log_index;
		in_req.data.etype = req.event_type;
		in_req.data.remote = req.is_remote;
		in_req.data.value = req.event_value;
		in_req.data.thresh = req.threshold;
		in_req.data.window = req.window;
		in_req.data.stamp = req.timestamp;
	end

	oelt_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cap(cap_q),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.in_req(in_req),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_rsp(out_rsp),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	oelt_ram #(
		.DEPTH(MAX_ENTRIES),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rsp.status = out_rsp.status;
	assign rsp.out_interface_id = out_rsp.rec.iface;
	assign rsp.out_log_index = out_rsp.rec.idx;
	assign rsp.out_event_type = out_rsp.rec.etype;
	assign rsp.out_is_remote = out_rsp.rec.remote;
	assign rsp.out_value = out_rsp.rec.value;
	assign rsp.out_threshold = out_rsp.rec.thresh;
	assign rsp.out_window = out_rsp.rec.window;
	assign rsp.out_timestamp = out_rsp.rec.stamp;

endmodule

>>> rtl/oelt_checker.sv
// Port-level checks of the event log table, bound to the top level.
// Depends on oelt_pkg and oam_event_log_table_macros.svh.
`include "oam_event_log_table_macros.svh"

module oelt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [31:0] rsp_iface,
	input logic [31:0] rsp_idx,
	input logic [31:0] rsp_stamp
);
	import oelt_pkg::*;

	// held result stays valid and keeps its log index
	`OELT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_idx))

	// one item at a time: busy right after an accept
	`OELT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

	`OELT_ASSERT_NOW(a_status_code, rsp_valid,
		rsp_status == ST_OK || rsp_status == ST_NOT_FOUND || rsp_status == ST_NO_NEXT)

	// a miss carries no record
	`OELT_ASSERT_NOW(a_miss_zero,
		rsp_valid && (rsp_status == ST_NOT_FOUND || rsp_status == ST_NO_NEXT),
		rsp_iface == 32'd0 && rsp_idx == 32'd0 && rsp_stamp == 32'd0)

endmodule

bind oam_event_log_table oelt_checker u_oelt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_status(rsp.status),
	.rsp_iface(rsp.out_interface_id),
	.rsp_idx(rsp.out_log_index),
	.rsp_stamp(rsp.out_timestamp)
);
